// File: sv/hns_pkg.sv
// Shared types and constants of the heightmap normal stencil.
package hns_pkg;

    localparam int BASE_CHUNK   = 50;
    localparam int SIDE_RESET   = BASE_CHUNK + 4;
    localparam int MAX_SIDE_DEF = 64;

    localparam int HEIGHT_W = 16;
    localparam int NORM_W   = 16;
    localparam int SIDE_W   = 7;

    localparam int Y_TERM   = 512;
    localparam int YSQ      = Y_TERM * Y_TERM;
    localparam int ONE_Q14  = 16384;

    localparam int Q_W       = 15;
    localparam int DIFF_W    = HEIGHT_W + 1;
    localparam int MAG_W     = 16;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int LEN_W     = 34;
    localparam int HALF_W    = LEN_W / 2;
    localparam int KK_W      = 30;
    localparam int PROD_W    = KK_W + HALF_W;
    localparam int CMP_W     = 64;
    localparam int RHS_SHIFT = 30;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LOAD,
        OP_SQX,
        OP_SQZ,
        OP_LEN,
        OP_INIT,
        OP_KK,
        OP_PLO,
        OP_PHI,
        OP_CMP,
        OP_PUBLISH
    } op_t;

    typedef enum logic [1:0] {
        COMP_X,
        COMP_Y,
        COMP_Z
    } comp_t;

    typedef struct packed {
        op_t   op;
        comp_t comp;
    } hns_cmd_t;

    typedef struct packed {
        logic has_result;
        logic bit_last;
    } hns_status_t;

endpackage

// File: sv/hns_in_if.sv
// Input channel: one height sample per beat.
interface hns_in_if;
    import hns_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] height;

    modport source (output valid, output height, input ready);
    modport sink   (input valid, input height, output ready);
endinterface

// File: sv/hns_out_if.sv
// Output channel: one unit normal per beat.
interface hns_out_if;
    import hns_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     last_normal;

    modport source (output valid, output normal_x, output normal_y, output normal_z,
                    output last_normal, input ready);
    modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                    input last_normal, output ready);
endinterface

// File: sv/hns_ram.sv
// Generic single write, single read RAM with registered read data.
module hns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: sv/hns_datapath.sv
// Datapath: line stores, window, counters, shared multiplier and bisection.
module hns_datapath #(
    parameter int MAX_SIDE = hns_pkg::MAX_SIDE_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  hns_pkg::hns_cmd_t                  cmd,
    output hns_pkg::hns_status_t               status,
    input  logic                               grid_side_we,
    input  logic [hns_pkg::SIDE_W-1:0]         grid_side_wdata,
    input  logic signed [hns_pkg::HEIGHT_W-1:0] height,
    output logic signed [hns_pkg::NORM_W-1:0]   normal_x,
    output logic signed [hns_pkg::NORM_W-1:0]   normal_y,
    output logic signed [hns_pkg::NORM_W-1:0]   normal_z,
    output logic                               last_normal
);
    import hns_pkg::*;

    localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CW = $clog2(MAX_SIDE + 1);

    logic [SIDE_W-1:0] side_cfg_reg;
    logic [AW-1:0]     col_reg, row_reg;
    logic [CW-1:0]     side_eff, side_m1;
    logic              col_wrap, row_wrap;

    logic signed [HEIGHT_W-1:0] h_reg;
    logic                       has_res_reg, last_reg;
    logic signed [HEIGHT_W-1:0] w0_reg, w1_reg, w2_reg, w4_reg;
    logic signed [HEIGHT_W-1:0] top_rd, mid_rd;
    logic signed [DIFF_W-1:0]   dx_reg, dz_reg;
    logic [MAG_W-1:0]           mag_x, mag_z;

    logic [SQ_W-1:0]   sqx_reg, sqz_reg, sq_sel;
    logic [LEN_W-1:0]  len2_reg;
    logic [PROD_W-1:0] prod_reg, plo_reg, prod_next;
    logic [KK_W-1:0]   kk_reg, mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [Q_W-1:0]    q_reg, bit_reg, t_val, q_new;
    logic [Q_W:0]      k_val;
    logic [CMP_W-1:0]  lhs, rhs;
    logic              fits, neg_sel;
    logic [NORM_W-1:0] signed_q;
    logic [NORM_W-1:0] res_x_reg, res_y_reg, res_z_reg;

    // Clamp the configured side into 3 .. MAX_SIDE.
    always_comb
    begin
        priority if (side_cfg_reg < SIDE_W'(3))
        begin
            side_eff = CW'(3);
        end
        else if (int'(side_cfg_reg) > MAX_SIDE)
        begin
            side_eff = CW'(MAX_SIDE);
        end
        else
        begin
            side_eff = CW'(side_cfg_reg);
        end
    end

    assign side_m1  = side_eff - CW'(1);
    assign col_wrap = (CW'(col_reg) == side_m1);
    assign row_wrap = (CW'(row_reg) == side_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_cfg_reg <= SIDE_W'(SIDE_RESET);
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (grid_side_we)
        begin
            side_cfg_reg <= grid_side_wdata;
            col_reg      <= '0;
            row_reg      <= '0;
        end
        else if (cmd.op == OP_LOAD)
        begin
            if (col_wrap)
            begin
                col_reg <= '0;
                row_reg <= row_wrap ? '0 : row_reg + AW'(1);
            end
            else
            begin
                col_reg <= col_reg + AW'(1);
            end
        end
    end

    hns_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_SIDE)) u_row_older (
        .clk   (clk),
        .we    (cmd.op == OP_LOAD),
        .waddr (col_reg),
        .wdata (mid_rd),
        .raddr (col_reg),
        .rdata (top_rd)
    );

    hns_ram #(.WIDTH(HEIGHT_W), .DEPTH(MAX_SIDE)) u_row_newer (
        .clk   (clk),
        .we    (cmd.op == OP_LOAD),
        .waddr (col_reg),
        .wdata (h_reg),
        .raddr (col_reg),
        .rdata (mid_rd)
    );

    assign mag_x = MAG_W'(dx_reg[DIFF_W-1] ? -dx_reg : dx_reg);
    assign mag_z = MAG_W'(dz_reg[DIFF_W-1] ? -dz_reg : dz_reg);

    assign t_val = q_reg | bit_reg;
    assign k_val = {t_val, 1'b0} - (Q_W+1)'(1);

    always_comb
    begin
        unique case (cmd.op)
            OP_SQX:
            begin
                mul_a = KK_W'(mag_x);
                mul_b = HALF_W'(mag_x);
            end
            OP_SQZ:
            begin
                mul_a = KK_W'(mag_z);
                mul_b = HALF_W'(mag_z);
            end
            OP_KK:
            begin
                mul_a = KK_W'(k_val);
                mul_b = HALF_W'(k_val);
            end
            OP_PLO:
            begin
                mul_a = KK_W'(prod_reg);
                mul_b = len2_reg[HALF_W-1:0];
            end
            OP_PHI:
            begin
                mul_a = kk_reg;
                mul_b = len2_reg[LEN_W-1:HALF_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);

    always_comb
    begin
        unique case (cmd.comp)
            COMP_X:
            begin
                sq_sel  = sqx_reg;
                neg_sel = dx_reg[DIFF_W-1];
            end
            COMP_Y:
            begin
                sq_sel  = SQ_W'(YSQ);
                neg_sel = 1'b0;
            end
            COMP_Z:
            begin
                sq_sel  = sqz_reg;
                neg_sel = dz_reg[DIFF_W-1];
            end
            default:
            begin
                sq_sel  = '0;
                neg_sel = 1'b0;
            end
        endcase
    end

    // k*k*len2 <= (32768*mag)^2 decides one bit of the rounded quotient.
    assign lhs      = (CMP_W'(prod_reg) << HALF_W) + CMP_W'(plo_reg);
    assign rhs      = CMP_W'(sq_sel) << RHS_SHIFT;
    assign fits     = (t_val <= Q_W'(ONE_Q14)) && (lhs <= rhs);
    assign q_new    = fits ? t_val : q_reg;
    assign signed_q = neg_sel ? -NORM_W'(q_new) : NORM_W'(q_new);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            has_res_reg <= 1'b0;
            bit_reg     <= '0;
        end
        else
        begin
            unique case (cmd.op)
                OP_ACCEPT:
                begin
                    has_res_reg <= (row_reg >= AW'(2)) && (col_reg >= AW'(2));
                end
                OP_INIT:
                begin
                    bit_reg <= Q_W'(ONE_Q14);
                end
                OP_CMP:
                begin
                    bit_reg <= bit_reg >> 1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_ACCEPT:
            begin
                h_reg    <= height;
                last_reg <= row_wrap && col_wrap;
            end
            OP_LOAD:
            begin
                dx_reg <= DIFF_W'(w2_reg) - DIFF_W'(w0_reg);
                dz_reg <= DIFF_W'(mid_rd) - DIFF_W'(w4_reg);
                w4_reg <= w1_reg;
                w0_reg <= top_rd;
                w1_reg <= mid_rd;
                w2_reg <= h_reg;
            end
            OP_SQX:
            begin
                prod_reg <= prod_next;
            end
            OP_SQZ:
            begin
                sqx_reg  <= SQ_W'(prod_reg);
                prod_reg <= prod_next;
            end
            OP_LEN:
            begin
                sqz_reg  <= SQ_W'(prod_reg);
                len2_reg <= LEN_W'(sqx_reg) + LEN_W'(prod_reg[SQ_W-1:0]) + LEN_W'(YSQ);
            end
            OP_INIT:
            begin
                q_reg <= '0;
            end
            OP_KK:
            begin
                prod_reg <= prod_next;
            end
            OP_PLO:
            begin
                kk_reg   <= KK_W'(prod_reg);
                prod_reg <= prod_next;
            end
            OP_PHI:
            begin
                plo_reg  <= prod_reg;
                prod_reg <= prod_next;
            end
            OP_CMP:
            begin
                q_reg <= q_new;
                if (bit_reg[0])
                begin
                    unique case (cmd.comp)
                        COMP_X:  res_x_reg <= signed_q;
                        COMP_Y:  res_y_reg <= signed_q;
                        COMP_Z:  res_z_reg <= signed_q;
                        default: res_x_reg <= res_x_reg;
                    endcase
                end
            end
            OP_PUBLISH:
            begin
                normal_x    <= res_x_reg;
                normal_y    <= res_y_reg;
                normal_z    <= res_z_reg;
                last_normal <= last_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status.has_result = has_res_reg;
    assign status.bit_last   = bit_reg[0];

`ifndef SYNTHESIS
    a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_KK || cmd.op == OP_CMP) |-> q_reg <= Q_W'(ONE_Q14))
        else $error("quotient above one");
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(col_reg) < side_eff && CW'(row_reg) < side_eff)
        else $error("grid counter out of range");
    a_bit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_KK || cmd.op == OP_CMP) |-> $onehot(bit_reg))
        else $error("bisection bit lost");
`endif
endmodule

// File: sv/hns_ctrl.sv
// Controller: sequences accept, line store update, squares and bisection.
module hns_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  hns_pkg::hns_status_t status,
    output hns_pkg::hns_cmd_t    cmd
);
    import hns_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_SQX,
        S_SQZ,
        S_LEN,
        S_INIT,
        S_KK,
        S_PLO,
        S_PHI,
        S_CMP,
        S_DONE
    } state_t;

    state_t state_reg;
    comp_t  comp_reg;
    logic   out_valid_reg;
    logic   pub_ok;

    assign pub_ok    = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd.comp  = comp_reg;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  cmd.op = in_valid ? OP_ACCEPT : OP_NONE;
            S_LOAD:  cmd.op = OP_LOAD;
            S_SQX:   cmd.op = OP_SQX;
            S_SQZ:   cmd.op = OP_SQZ;
            S_LEN:   cmd.op = OP_LEN;
            S_INIT:  cmd.op = OP_INIT;
            S_KK:    cmd.op = OP_KK;
            S_PLO:   cmd.op = OP_PLO;
            S_PHI:   cmd.op = OP_PHI;
            S_CMP:   cmd.op = OP_CMP;
            S_DONE:  cmd.op = pub_ok ? OP_PUBLISH : OP_NONE;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            comp_reg      <= COMP_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && pub_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD:
                begin
                    state_reg <= status.has_result ? S_SQX : S_IDLE;
                end
                S_SQX:
                begin
                    state_reg <= S_SQZ;
                end
                S_SQZ:
                begin
                    state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    comp_reg  <= COMP_X;
                    state_reg <= S_INIT;
                end
                S_INIT:
                begin
                    state_reg <= S_KK;
                end
                S_KK:
                begin
                    state_reg <= S_PLO;
                end
                S_PLO:
                begin
                    state_reg <= S_PHI;
                end
                S_PHI:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (!status.bit_last)
                    begin
                        state_reg <= S_KK;
                    end
                    else if (comp_reg == COMP_Z)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        comp_reg  <= (comp_reg == COMP_X) ? COMP_Y : COMP_Z;
                        state_reg <= S_INIT;
                    end
                end
                S_DONE:
                begin
                    if (pub_ok)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_valid) |=> state_reg == S_LOAD)
        else $error("accepted beat not loaded");
    a_publish: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && pub_ok) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("result not published");
    a_next_comp: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP && status.bit_last && comp_reg != COMP_Z)
        |=> state_reg == S_INIT)
        else $error("component sequence broken");
`endif
endmodule

// File: sv/heightmap_normal_stencil.sv
// Top level of the heightmap normal stencil.
// Heights arrive on the samples channel in raster order (rows outer, columns inner),
// grid_side by grid_side per grid, and for each interior sample one unit normal in
// signed Q1.14 leaves on the normals channel, along (dx, 512, dz) with central
// differences, each component rounded to nearest with ties away from zero; last_normal
// marks the final normal of a grid. The normal for center (x, z) leaves after the beat
// carrying sample (x+1, z+1). One item is worked at a time: a border sample only
// updates the line stores and window, and a sample that yields a normal runs three
// 15-step bisections, one per component, each step on one shared 30x17 multiplier
// (k*k, then k*k times the two halves of the squared length, then compare). A finished
// normal waits in an output register, so the next sample beat is taken while it is
// still unread. Write grid_side only while idle; a write restarts the grid. Values
// below 3 act as 3 and values above MAX_SIDE act as MAX_SIDE.
module heightmap_normal_stencil #(
    parameter int MAX_SIDE = hns_pkg::MAX_SIDE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    hns_in_if.sink                     samples,
    hns_out_if.source                  normals,
    input  logic                       grid_side_we,
    input  logic [hns_pkg::SIDE_W-1:0] grid_side_wdata
);
    import hns_pkg::*;

    hns_cmd_t    cmd;
    hns_status_t status;

    // Sequence each beat: accept, update line stores, then for an interior sample run the normal math.
    hns_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (normals.valid),
        .out_ready (normals.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Hold the line stores, window, grid counters and the arithmetic.
    hns_datapath #(.MAX_SIDE(MAX_SIDE)) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .grid_side_we    (grid_side_we),
        .grid_side_wdata (grid_side_wdata),
        .height          (samples.height),
        .normal_x        (normals.normal_x),
        .normal_y        (normals.normal_y),
        .normal_z        (normals.normal_z),
        .last_normal     (normals.last_normal)
    );
endmodule

// File: tb/sv/heightmap_normal_stencil_test.sv
// Self-checking testbench of the heightmap normal stencil: directed and random grids.
`timescale 1ns / 100ps

module heightmap_normal_stencil_test;
    import hns_pkg::*;

    localparam int MAX_SIDE   = 64;
    localparam int IDLE_LIMIT = 20000;
    // Allow an interior sample still in flight to finish, plus margin, before config writes.
    localparam int DRAIN_WAIT = 400;

    typedef struct packed {
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               last;
    } normal_t;

    typedef struct {
        logic signed [15:0] height;
        logic               known;   // expected normal typed in below
        normal_t            fixed_normal;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic grid_side_we;
    logic [SIDE_W-1:0] grid_side_wdata;

    hns_in_if  samples ();
    hns_out_if normals ();

    heightmap_normal_stencil DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .samples        (samples.sink),
        .normals        (normals.source),
        .grid_side_we   (grid_side_we),
        .grid_side_wdata(grid_side_wdata)
    );

    // Shadow copy of the stencil state.
    logic [6:0]         side_reg;
    logic signed [15:0] rows_older [MAX_SIDE];
    logic signed [15:0] rows_newer [MAX_SIDE];
    logic signed [15:0] win [6];
    int unsigned        col_cnt;
    int unsigned        row_cnt;

    normal_t     normals_due[$];
    int          fail_count;
    int          idle_cycles;
    bit          quiet_phase;   // no idling on either side while set
    stim_row_t   directed[$];

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int unsigned clamped_side();
        int unsigned s;
        s = side_reg;
        if (s < 3) s = 3;
        if (s > MAX_SIDE) s = MAX_SIDE;
        return s;
    endfunction

    // Round 16384*v/sqrt(len2) to nearest, ties away from zero, by bit-wise search.
    function automatic logic signed [15:0] unit_part(input longint v, input longint unsigned len2);
        longint unsigned mag;
        longint unsigned rhs;
        longint unsigned k;
        int unsigned     q;
        int unsigned     t;
        mag = (v < 0) ? -v : v;
        rhs = (32768 * mag) * (32768 * mag);
        q = 0;
        for (int b = 14; b >= 0; b--)
        begin
            t = q | (1 << b);
            if (t > ONE_Q14) continue;
            k = 2 * longint'(t) - 1;
            if (k * k * len2 <= rhs) q = t;
        end
        return (v < 0) ? -$signed(16'(q)) : $signed(16'(q));
    endfunction

    // Advance the shadow stencil by one sample; queue a normal for interior centers.
    task automatic predict_normal(input logic signed [15:0] h);
        longint             dx;
        longint             dz;
        longint unsigned    len2;
        logic signed [15:0] top_c;
        logic signed [15:0] mid_c;
        int unsigned        side;
        normal_t            n;
        side  = clamped_side();
        top_c = rows_older[col_cnt];
        mid_c = rows_newer[col_cnt];
        if (row_cnt >= 2 && col_cnt >= 2)
        begin
            dx   = longint'(win[2]) - longint'(win[0]);
            dz   = longint'(mid_c) - longint'(win[4]);
            len2 = dx * dx + dz * dz + Y_TERM * Y_TERM;
            n.nx = unit_part(dx, len2);
            n.ny = unit_part(Y_TERM, len2);
            n.nz = unit_part(dz, len2);
            n.last = (row_cnt == side - 1) && (col_cnt == side - 1);
            normals_due.push_back(n);
        end
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = top_c;
        win[1] = mid_c;
        win[2] = h;
        rows_older[col_cnt] = mid_c;
        rows_newer[col_cnt] = h;
        col_cnt++;
        if (col_cnt >= side)
        begin
            col_cnt = 0;
            row_cnt++;
            if (row_cnt >= side) row_cnt = 0;
        end
    endtask

    // Send one sample beat; hold valid until the block takes it.
    task automatic send_height(input logic signed [15:0] h);
        if (!quiet_phase)
        begin
            while ($urandom_range(99) < 7)
            begin
                samples.valid <= 1'b0;
                @(negedge clk);
            end
        end
        samples.valid  <= 1'b1;
        samples.height <= h;
        @(posedge clk);
        while (!samples.ready) @(posedge clk);
        predict_normal(h);
        @(negedge clk);
    endtask

    // Drop valid, wait for every queued normal, then let any border beat in flight finish.
    task automatic drain();
        samples.valid <= 1'b0;
        while (normals_due.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    // Write grid_side while idle; the grid restarts.
    task automatic write_side(input logic [SIDE_W-1:0] s);
        drain();
        grid_side_we    <= 1'b1;
        grid_side_wdata <= s;
        @(negedge clk);
        grid_side_we <= 1'b0;
        side_reg = s;
        col_cnt  = 0;
        row_cnt  = 0;
    endtask

    // Send a full grid by style: raw noise, a well-formed surface, or random full-scale extremes.
    task automatic send_grid(input int unsigned side, input int style);
        logic signed [15:0] h;
        int                 base;
        base = $urandom_range(4000) - 2000;
        for (int x = 0; x < side; x++)
        begin
            for (int z = 0; z < side; z++)
            begin
                case (style)
                    0: h = 16'($urandom);
                    1: h = 16'(base + x * 37 - z * 21 + int'($urandom_range(64)) - 32);
                    default: h = ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
                endcase
                send_height(h);
            end
        end
    endtask

    // Output side: random stall, check each accepted beat against the oldest expectation.
    initial
    begin
        normals.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            normals.ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 7);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && normals.valid && normals.ready)
        begin
            if (normals_due.size() == 0)
            begin
                report_mismatch("unexpected normal", normals.normal_x, 0);
            end
            else
            begin
                normal_t w;
                w = normals_due.pop_front();
                if (normals.normal_x !== w.nx) report_mismatch("normal_x", normals.normal_x, w.nx);
                if (normals.normal_y !== w.ny) report_mismatch("normal_y", normals.normal_y, w.ny);
                if (normals.normal_z !== w.nz) report_mismatch("normal_z", normals.normal_z, w.nz);
                if (normals.last_normal !== w.last)
                    report_mismatch("last_normal", normals.last_normal, w.last);
            end
        end
    end

    // Watchdog: count cycles with no beat on either channel.
    always @(posedge clk)
    begin
        if ((samples.valid && samples.ready) || (normals.valid && normals.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic stim_row_t mk_row(input logic signed [15:0] h, input bit known,
                                         input int nx, input int ny, input int nz,
                                         input bit last);
        stim_row_t r;
        r.height = h;
        r.known  = known;
        r.fixed_normal.nx = 16'(nx);
        r.fixed_normal.ny = 16'(ny);
        r.fixed_normal.nz = 16'(nz);
        r.fixed_normal.last = last;
        return r;
    endfunction

    initial
    begin
        int sent;
        fail_count      = 0;
        idle_cycles     = 0;
        quiet_phase     = 1'b0;
        rst_n           = 1'b0;
        grid_side_we    = 1'b0;
        grid_side_wdata = '0;
        samples.valid   = 1'b0;
        samples.height  = '0;
        side_reg        = 7'(SIDE_RESET);
        col_cnt         = 0;
        row_cnt         = 0;
        foreach (rows_older[i]) rows_older[i] = '0;
        foreach (rows_newer[i]) rows_newer[i] = '0;
        foreach (win[i]) win[i] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset side: three rows of the default grid, one row of normals.
        for (int i = 0; i < 3 * SIDE_RESET; i++) send_height(16'($urandom));

        // Directed: a flat 3x3 grid gives the straight-up normal, flagged last;
        // then a 3x3 grid with opposite extremes around the center.
        directed.push_back(mk_row(16'sd0, 0, 0, 0, 0, 0));
        write_side(7'd3);
        for (int i = 0; i < 8; i++) directed.push_back(mk_row(16'sd0, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(16'sd0, 1, 0, ONE_Q14, 0, 1));
        directed.push_back(mk_row(16'sh8000, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(16'sh8000, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(16'sh7fff, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(16'sh8000, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(16'sh0000, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(16'sh7fff, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(16'sh7fff, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(16'sh8000, 0, 0, 0, 0, 0));
        directed.push_back(mk_row(16'sh7fff, 0, 0, 0, 0, 0));
        // Walk the table; the first row is a dummy marker and is skipped.
        for (int i = 1; i < directed.size(); i++)
        begin
            int before_n;
            before_n = normals_due.size();
            send_height(directed[i].height);
            if (directed[i].known && normals_due.size() > before_n)
            begin
                normal_t p;
                p = normals_due[normals_due.size() - 1];
                if (p != directed[i].fixed_normal)
                    report_mismatch("flat grid table", p.ny, directed[i].fixed_normal.ny);
            end
        end

        // Side out of range and minimum: 0 acts as 3; 127 acts as 64 (three rows and five samples).
        write_side(7'd0);
        send_grid(3, 2);
        write_side(7'd127);
        for (int i = 0; i < 3 * MAX_SIDE + 5; i++) send_height(16'($urandom));
        // Mid-grid restart: write during a partial grid.
        write_side(7'd5);
        for (int i = 0; i < 13; i++) send_height(16'($urandom));
        write_side(7'd5);

        // Random grids of small sides.
        sent = 0;
        while (sent < 800)
        begin
            int unsigned s;
            s = $urandom_range(3, 12);
            quiet_phase = ($urandom_range(5) == 0);
            write_side(7'(s));
            send_grid(s, ($urandom_range(3) == 0) ? 0 : 1);
            sent += s * s;
        end
        quiet_phase = 1'b0;
        drain();

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: files.f
sv/hns_pkg.sv
sv/hns_in_if.sv
sv/hns_out_if.sv
sv/hns_ram.sv
sv/hns_datapath.sv
sv/hns_ctrl.sv
sv/heightmap_normal_stencil.sv
tb/sv/heightmap_normal_stencil_test.sv
